FILE: design/ola_pkg.sv
`timescale 1ns / 1ps

package ola_pkg;

  localparam int DEPTH_DEF = 128;

  localparam logic [2:0] FN_SORTED = 3'd0;
  localparam logic [2:0] FN_INSERT = 3'd1;
  localparam logic [2:0] FN_DELETE = 3'd2;
  localparam logic [2:0] FN_READ   = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_POS,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    TGT_HOLD,
    TGT_IDX,
    TGT_POS
  } tgt_op_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_POS
  } rd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_REFUSE,
    RES_INSERT,
    RES_READ,
    RES_DELETE,
    RES_CLEAR
  } res_t;

  typedef struct packed {
    logic    req_ld;
    idx_op_t idx_op;
    tgt_op_t tgt_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_val;
    logic    word_ld;
    cnt_op_t cnt_op;
    res_t    res;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       ins_bad;
    logic       acc_bad;
    logic       idx_eq_cnt;
    logic       idx_eq_tgt;
    logic       idx_p1_eq_cnt;
    logic       val_lt_rd;
  } sts_t;

endpackage

FILE: design/ola_ctrl.sv
`timescale 1ns / 1ps

module ola_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ola_pkg::sts_t sts,
  output ola_pkg::cmd_t cmd
);
  import ola_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_SRCH_RD  = 10'b00_0000_0100,
    S_SRCH_CMP = 10'b00_0000_1000,
    S_INS_RD   = 10'b00_0001_0000,
    S_INS_WR   = 10'b00_0010_0000,
    S_DEL_CAP  = 10'b00_0100_0000,
    S_DEL_RD   = 10'b00_1000_0000,
    S_DEL_WR   = 10'b01_0000_0000,
    S_RD_CAP   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.idx_op  = IDX_HOLD;
    cmd.tgt_op  = TGT_HOLD;
    cmd.rd_sel  = RD_IDX;
    cmd.cnt_op  = CNT_HOLD;
    cmd.res     = RES_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.req_ld = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        unique case (sts.func)
          FN_SORTED: begin
            if (sts.full) begin
              cmd.res = RES_REFUSE;
            end else begin
              cmd.idx_op = IDX_ZERO;
              state_nxt  = S_SRCH_RD;
            end
          end
          FN_INSERT: begin
            if (sts.full || sts.ins_bad) begin
              cmd.res = RES_REFUSE;
            end else begin
              cmd.tgt_op = TGT_POS;
              cmd.idx_op = IDX_COUNT;
              state_nxt  = S_INS_RD;
            end
          end
          FN_DELETE: begin
            if (sts.acc_bad) begin
              cmd.res = RES_REFUSE;
            end else begin
              cmd.tgt_op = TGT_POS;
              cmd.idx_op = IDX_POS;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
              state_nxt  = S_DEL_CAP;
            end
          end
          FN_READ: begin
            if (sts.acc_bad) begin
              cmd.res = RES_REFUSE;
            end else begin
              cmd.tgt_op = TGT_POS;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
              state_nxt  = S_RD_CAP;
            end
          end
          FN_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
            cmd.res    = RES_CLEAR;
          end
          default: begin
            cmd.res = RES_REFUSE;
          end
        endcase
      end
      S_SRCH_RD: begin
        if (sts.idx_eq_cnt) begin
          cmd.tgt_op = TGT_IDX;
          cmd.idx_op = IDX_COUNT;
          state_nxt  = S_INS_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.val_lt_rd) begin
          cmd.tgt_op = TGT_IDX;
          cmd.idx_op = IDX_COUNT;
          state_nxt  = S_INS_RD;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_SRCH_RD;
        end
      end
      S_INS_RD: begin
        if (sts.idx_eq_tgt) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_val = 1'b1;
          cmd.cnt_op = CNT_INC;
          cmd.res    = RES_INSERT;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_nxt  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_DEC;
        state_nxt  = S_INS_RD;
      end
      S_DEL_CAP: begin
        cmd.word_ld = 1'b1;
        state_nxt   = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (sts.idx_p1_eq_cnt) begin
          cmd.cnt_op = CNT_DEC;
          cmd.res    = RES_DELETE;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
          state_nxt  = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_INC;
        state_nxt  = S_DEL_RD;
      end
      S_RD_CAP: begin
        cmd.res   = RES_READ;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/ola_dp.sv
`timescale 1ns / 1ps

module ola_dp #(
  parameter int DEPTH = ola_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  input  ola_pkg::cmd_t      cmd,
  output ola_pkg::sts_t      sts,
  output logic               out_strobe,
  output logic               out_ok,
  output logic signed [31:0] out_word_out,
  output logic [7:0]         out_used_position,
  output logic [7:0]         out_count
);
  import ola_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (CW > 8) ? CW : 8;

  logic signed [31:0] mem [DEPTH];

  logic [2:0]         func_r;
  logic [7:0]         pos_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      tgt_r, tgt_nxt;
  logic [CW-1:0]      idx_p1, idx_m1;
  logic signed [31:0] rdata_r;
  logic signed [31:0] word_r;
  logic [PW-1:0]      pos_ext, cnt_ext, tgt_ext, cnt_nxt_ext;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] wr_data;

  logic               strobe_r;
  logic               ok_r;
  logic signed [31:0] word_out_r;
  logic [7:0]         upos_r;
  logic [7:0]         count_r;

  assign idx_p1      = idx_r + CW'(1);
  assign idx_m1      = idx_r - CW'(1);
  assign pos_ext     = PW'(pos_r);
  assign cnt_ext     = PW'(cnt_r);
  assign tgt_ext     = PW'(tgt_r);
  assign cnt_nxt_ext = PW'(cnt_nxt);

  assign sts.func          = func_r;
  assign sts.full          = (cnt_r == CW'(DEPTH));
  assign sts.ins_bad       = (pos_ext > cnt_ext);
  assign sts.acc_bad       = (pos_ext >= cnt_ext);
  assign sts.idx_eq_cnt    = (idx_r == cnt_r);
  assign sts.idx_eq_tgt    = (idx_r == tgt_r);
  assign sts.idx_p1_eq_cnt = (idx_p1 == cnt_r);
  assign sts.val_lt_rd     = (val_r < rdata_r);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX:    rd_addr = idx_r[AW-1:0];
      RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
      RD_POS:    rd_addr = pos_ext[AW-1:0];
      default:   rd_addr = idx_r[AW-1:0];
    endcase
    wr_addr = cmd.wr_val ? tgt_r[AW-1:0] : idx_r[AW-1:0];
    wr_data = cmd.wr_val ? val_r : rdata_r;
  end

  always_comb begin
    unique case (cmd.idx_op)
      IDX_HOLD:  idx_nxt = idx_r;
      IDX_ZERO:  idx_nxt = '0;
      IDX_POS:   idx_nxt = pos_ext[CW-1:0];
      IDX_COUNT: idx_nxt = cnt_r;
      IDX_INC:   idx_nxt = idx_p1;
      IDX_DEC:   idx_nxt = idx_m1;
      default:   idx_nxt = idx_r;
    endcase
    unique case (cmd.tgt_op)
      TGT_HOLD: tgt_nxt = tgt_r;
      TGT_IDX:  tgt_nxt = idx_r;
      TGT_POS:  tgt_nxt = pos_ext[CW-1:0];
      default:  tgt_nxt = tgt_r;
    endcase
    unique case (cmd.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      CNT_DEC:  cnt_nxt = cnt_r - CW'(1);
      CNT_CLR:  cnt_nxt = '0;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      strobe_r <= (cmd.res != RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      func_r <= in_func;
      pos_r  <= in_position;
      val_r  <= in_value;
    end
    if (cmd.word_ld) begin
      word_r <= rdata_r;
    end
    idx_r <= idx_nxt;
    tgt_r <= tgt_nxt;
    if (cmd.res != RES_NONE) begin
      count_r <= cnt_nxt_ext[7:0];
      unique case (cmd.res)
        RES_INSERT: begin
          ok_r       <= 1'b1;
          word_out_r <= '0;
          upos_r     <= tgt_ext[7:0];
        end
        RES_READ: begin
          ok_r       <= 1'b1;
          word_out_r <= rdata_r;
          upos_r     <= tgt_ext[7:0];
        end
        RES_DELETE: begin
          ok_r       <= 1'b1;
          word_out_r <= word_r;
          upos_r     <= tgt_ext[7:0];
        end
        RES_CLEAR: begin
          ok_r       <= 1'b1;
          word_out_r <= '0;
          upos_r     <= '0;
        end
        default: begin
          ok_r       <= 1'b0;
          word_out_r <= '0;
          upos_r     <= '0;
        end
      endcase
    end
  end

  assign out_strobe        = strobe_r;
  assign out_ok            = ok_r;
  assign out_word_out      = word_out_r;
  assign out_used_position = upos_r;
  assign out_count         = count_r;

endmodule

FILE: design/ordered_array_list_engine.sv
`timescale 1ns / 1ps
// one transaction at a time; start is taken only while busy is low
// clear or refusal ends in dispatch, read in a capture state; insert/delete loop over entries
// the search loop reads then compares each entry; the shift loops read then write each entry
// throughput: next transaction may start in the cycle its predecessor's strobe is high
// results are a one-cycle strobe and cannot be stalled; rst_n is synchronous and empties the list

module ordered_array_list_engine #(
  parameter int DEPTH = ola_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic               out_ok,
  output logic signed [31:0] out_word_out,
  output logic [7:0]         out_used_position,
  output logic [7:0]         out_count
);
  import ola_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ola_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ola_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_func           (in_func),
    .in_position       (in_position),
    .in_value          (in_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_strobe        (out_strobe),
    .out_ok            (out_ok),
    .out_word_out      (out_word_out),
    .out_used_position (out_used_position),
    .out_count         (out_count)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while still busy");

  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_ok |-> out_word_out == 32'sd0 && out_used_position == 8'd0)
    else $error("refused transaction carries data");

endmodule

FILE: dv/ola_list_checker.sv
`timescale 1ns / 1ps

module ola_list_checker #(
  parameter int DEPTH = ola_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  input  logic               out_strobe,
  input  logic               out_ok,
  input  logic signed [31:0] out_word_out,
  input  logic [7:0]         out_used_position,
  input  logic [7:0]         out_count,
  input  logic               end_check,
  output int                 fail_count
);
  import ola_pkg::*;

  typedef struct {
    logic               ok;
    logic signed [31:0] word;
    logic [7:0]         slot;
    logic [7:0]         cnt;
  } list_resp_t;

  logic signed [31:0] list_mem [DEPTH];
  int                 list_len = 0;
  list_resp_t         resp_q [$];
  int                 err_cnt = 0;
  logic               end_done = 1'b0;

  assign fail_count = err_cnt;

  function automatic void open_slot(int at, logic signed [31:0] val);
    int i;
    for (i = list_len; i > at; i--) list_mem[i] = list_mem[i - 1];
    list_mem[at] = val;
    list_len++;
  endfunction

  function automatic list_resp_t apply_request(logic [2:0] fn, logic [7:0] pos,
                                               logic signed [31:0] val);
    list_resp_t r;
    int         slot;
    int         i;
    r = '{ok: 1'b0, word: '0, slot: '0, cnt: '0};
    case (fn)
      FN_SORTED: begin
        if (list_len < DEPTH) begin
          slot = 0;
          while (slot < list_len && !(val < list_mem[slot])) slot++;
          open_slot(slot, val);
          r.ok   = 1'b1;
          r.slot = slot[7:0];
        end
      end
      FN_INSERT: begin
        if (list_len < DEPTH && int'(pos) <= list_len) begin
          open_slot(int'(pos), val);
          r.ok   = 1'b1;
          r.slot = pos;
        end
      end
      FN_DELETE: begin
        if (int'(pos) < list_len) begin
          r.word = list_mem[pos];
          for (i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
          r.ok   = 1'b1;
          r.slot = pos;
        end
      end
      FN_READ: begin
        if (int'(pos) < list_len) begin
          r.word = list_mem[pos];
          r.ok   = 1'b1;
          r.slot = pos;
        end
      end
      FN_CLEAR: begin
        list_len = 0;
        r.ok     = 1'b1;
      end
      default: begin
      end
    endcase
    r.cnt = list_len[7:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    list_resp_t want;
    if (!rst_n) begin
      list_len = 0;
      resp_q.delete();
    end else begin
      if (out_strobe) begin
        if (resp_q.size() == 0) begin
          $display("%0t: result with no transaction pending: ok %0b word %0h pos %0d count %0d",
                   $time, out_ok, out_word_out, out_used_position, out_count);
          err_cnt++;
        end else begin
          want = resp_q.pop_front();
          check_field("ok", 32'(out_ok), 32'(want.ok));
          check_field("word_out", out_word_out, want.word);
          check_field("used_position", 32'(out_used_position), 32'(want.slot));
          check_field("count", 32'(out_count), 32'(want.cnt));
        end
      end
      if (start && !busy) resp_q.push_back(apply_request(in_func, in_position, in_value));
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (resp_q.size() != 0) begin
          $display("%0t: %0d results never arrived", $time, resp_q.size());
          err_cnt += resp_q.size();
        end
      end
    end
  end

endmodule

FILE: dv/tb_ordered_array_list_engine.sv
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
  import ola_pkg::*;

  localparam int         DEPTH       = DEPTH_DEF;
  localparam int         CYCLE_LIMIT = 1_200_000;
  localparam logic [2:0] FN_BAD_LO   = 3'd5;
  localparam logic [2:0] FN_BAD_HI   = 3'd7;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               start       = 1'b0;
  logic [2:0]         in_func     = FN_CLEAR;
  logic [7:0]         in_position = '0;
  logic signed [31:0] in_value    = '0;
  logic               end_check   = 1'b0;
  logic               busy;
  logic               out_strobe;
  logic               out_ok;
  logic signed [31:0] out_word_out;
  logic [7:0]         out_used_position;
  logic [7:0]         out_count;
  int                 fail_count;
  int                 issued_cnt = 0;
  int                 done_cnt   = 0;
  int                 len_hint   = 0;
  int                 idle_pct   = 0;
  int                 cycle_cnt  = 0;

  ordered_array_list_engine #(.DEPTH(DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_ok           (out_ok),
    .out_word_out     (out_word_out),
    .out_used_position(out_used_position),
    .out_count        (out_count)
  );

  ola_list_checker #(.DEPTH(DEPTH)) list_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_ok           (out_ok),
    .out_word_out     (out_word_out),
    .out_used_position(out_used_position),
    .out_count        (out_count),
    .end_check        (end_check),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      done_cnt <= done_cnt + 1;
      len_hint <= int'(out_count);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic issue(logic [2:0] fn, logic [7:0] pos, logic signed [31:0] val);
    int gap;
    start       <= 1'b1;
    in_func     <= fn;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued_cnt++;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (idle_pct > 0 && $urandom_range(0, 19) == 0) gap = $urandom_range(1, 300);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (done_cnt != issued_cnt) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_random(int ins_pct, int clr_pct);
    int                 pick;
    logic [2:0]         fn;
    logic [7:0]         pos;
    logic signed [31:0] val;
    pick = $urandom_range(0, 99);
    val  = pick_value();
    if (pick < ins_pct) fn = $urandom_range(0, 1) ? FN_SORTED : FN_INSERT;
    else if (pick < ins_pct + clr_pct) fn = FN_CLEAR;
    else if (pick >= 98) fn = 3'($urandom_range(FN_BAD_LO, FN_BAD_HI));
    else fn = $urandom_range(0, 1) ? FN_DELETE : FN_READ;
    if ($urandom_range(0, 9) == 0) pos = 8'($urandom_range(0, DEPTH));
    else if (fn == FN_INSERT) pos = 8'($urandom_range(0, len_hint));
    else if (len_hint > 0) pos = 8'($urandom_range(0, len_hint - 1));
    else pos = '0;
    issue(fn, pos, val);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, extremes, ties, edges of the range
    idle_pct = 0;
    issue(FN_READ, 8'd0, 32'sd0);
    issue(FN_DELETE, 8'd0, -32'sd1);
    issue(FN_SORTED, 8'd0, 32'sd0);
    issue(FN_SORTED, 8'd0, 32'sh7fffffff);
    issue(FN_SORTED, 8'd0, 32'sh80000000);
    issue(FN_SORTED, 8'd0, 32'sd0);
    issue(FN_SORTED, 8'd0, -32'sd1);
    issue(FN_INSERT, 8'd0, 32'sd5);
    issue(FN_INSERT, 8'd6, -32'sd5);
    issue(FN_INSERT, 8'd8, 32'sd9);
    issue(FN_READ, 8'd0, 32'sd0);
    issue(FN_READ, 8'd6, 32'sd0);
    issue(FN_READ, 8'd7, 32'sd0);
    issue(FN_DELETE, 8'd128, 32'sd0);
    issue(FN_DELETE, 8'd0, 32'sd0);
    issue(FN_DELETE, 8'd5, 32'sd0);
    issue(FN_BAD_LO, 8'd0, 32'sd1);
    issue(FN_BAD_HI, 8'd128, -32'sd1);
    issue(FN_CLEAR, 8'd0, 32'sd0);
    issue(FN_READ, 8'd0, 32'sd0);
    issue(FN_INSERT, 8'd0, 32'sd1);
    issue(FN_INSERT, 8'd128, 32'sd2);

    // fill toward full
    idle_pct = 68;
    repeat (160) issue_random(92, 0);
    drain();

    // top up to a full list, hit the full-list refusals, then access the last slot and delete the first entry
    idle_pct = 0;
    repeat (DEPTH - len_hint) issue(FN_SORTED, 8'd0, pick_value());
    issue(FN_SORTED, 8'd0, 32'sd0);
    issue(FN_INSERT, 8'd0, 32'sd0);
    issue(FN_INSERT, 8'd128, 32'sd0);
    issue(FN_READ, 8'd127, 32'sd0);
    issue(FN_DELETE, 8'd127, 32'sd0);
    issue(FN_INSERT, 8'd127, 32'sh80000000);
    issue(FN_DELETE, 8'd0, 32'sd0);

    idle_pct = 0;
    repeat (150) issue_random(50, 1);
    idle_pct = 10;
    repeat (120) issue_random(25, 0);
    idle_pct = 68;
    repeat (150) issue_random(55, 4);

    drain();
    repeat (20) @(posedge clk);
    end_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
